FILE: src/gyro_closed_loop_spin_turn_unit_macros.svh
// Assertion macros for the spin turn unit RTL.
// Included by modules that carry concurrent checks; relies on clock and reset in scope.
`ifndef GYRO_CLOSED_LOOP_SPIN_TURN_UNIT_MACROS_SVH
`define GYRO_CLOSED_LOOP_SPIN_TURN_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock outside reset
`define GCST_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gcst check failed");
// Next-cycle implication, checked on every rising clock outside reset
`define GCST_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gcst check failed");
`else
`define GCST_ASSERT_IMPL(lbl, ante, cons)
`define GCST_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/gcst_pkg.sv
// Shared widths, constants and control types of the spin turn unit.
// No dependencies; used by every module of the block.
`default_nettype none

package gcst_pkg;

   // Field widths
   localparam int ACCUM_WIDTH = 40;
   localparam int TGT_W       = 14;
   localparam int RATE_W      = 16;
   localparam int MS_W        = 10;
   localparam int SPD_W       = 11;
   localparam int SPD_MAG_W   = 10;
   localparam int MAG_W       = 13;
   localparam int ELAP_W      = 17;
   localparam int INC_W       = RATE_W + MS_W + 1;
   localparam int REM_W       = 23;
   localparam int GAIN_W      = 8;
   localparam int PRE_SHIFT   = 7;
   localparam int SCALE_W     = REM_W + GAIN_W;
   localparam int SCALED_W    = SCALE_W - PRE_SHIFT;
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 31;
   localparam int RECIP_PW    = SCALED_W + RECIP_W;
   localparam int QUO_W       = 17;

   // Port widths
   localparam int REQ_DATA_W  = TGT_W + RATE_W + MS_W;
   localparam int RSP_DATA_W  = 2 * SPD_W + 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // Constants
   localparam int                    MILLI       = 1000;
   localparam logic [MAG_W-1:0]      MAG_MAX     = 13'd8191;
   localparam logic [ELAP_W-1:0]     ELAPSED_MAX = 17'd131071;
   localparam logic [SPD_MAG_W-1:0]  MIN_SPEED   = 10'd80;
   // ceil(2^31 / 125): exact quotient for any 24-bit dividend
   localparam logic [RECIP_W-1:0]    RECIP_MUL   = 25'd17179870;

   // Opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOWDOWN_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_MS    = 2'd3;

   // Reset values
   localparam logic [9:0]  SPEED_LIMIT_RST   = 10'd400;
   localparam logic [7:0]  SLOWDOWN_GAIN_RST = 8'd15;
   localparam logic [7:0]  TOLERANCE_RST     = 8'd32;
   localparam logic [15:0] TIMEOUT_MS_RST    = 16'd5000;

   typedef struct packed {
      logic [9:0]  speed_limit;
      logic [7:0]  slowdown_gain;
      logic [7:0]  tolerance;
      logic [15:0] timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic do_mul;
      logic do_acc;
      logic do_abs;
      logic do_cmp;
      logic do_scale;
      logic do_recip;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic path_full;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

FILE: src/gcst_csr.sv
// Configuration registers of the spin turn unit.
// Depends on gcst_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module gcst_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gcst_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gcst_pkg::CSR_DATA_W-1:0]     csr_data,
   output gcst_pkg::cfg_type                   cfg
);

   gcst_pkg::cfg_type cfg_ff, cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;

   // Decode the register index of a write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gcst_pkg::REG_SPEED_LIMIT:   cfg_in.speed_limit   = csr_data[9:0];
            gcst_pkg::REG_SLOWDOWN_GAIN: cfg_in.slowdown_gain = csr_data[7:0];
            gcst_pkg::REG_TOLERANCE:     cfg_in.tolerance     = csr_data[7:0];
            gcst_pkg::REG_TIMEOUT_MS:    cfg_in.timeout_ms    = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_limit   <= gcst_pkg::SPEED_LIMIT_RST;
         cfg_ff.slowdown_gain <= gcst_pkg::SLOWDOWN_GAIN_RST;
         cfg_ff.tolerance     <= gcst_pkg::TOLERANCE_RST;
         cfg_ff.timeout_ms    <= gcst_pkg::TIMEOUT_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/gcst_dp.sv
// Datapath of the spin turn unit: turn state, integrator, scaling and result register.
// Depends on gcst_pkg; driven by commands from gcst_ctrl.
`default_nettype none

module gcst_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gcst_pkg::cmd_type                    cmd,
   input  gcst_pkg::cfg_type                    cfg,
   input  logic [gcst_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [gcst_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output gcst_pkg::sts_type                    sts
);

   localparam int AW = gcst_pkg::ACCUM_WIDTH;
   localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

   // Request fields
   logic [gcst_pkg::TGT_W-1:0]         req_target;
   logic signed [gcst_pkg::RATE_W-1:0] req_rate;
   logic [gcst_pkg::MS_W-1:0]          req_ms;

   // Turn state
   logic                               active_ff, active_in;
   logic                               cw_ff, cw_in;
   logic [gcst_pkg::MAG_W-1:0]         target_ff, target_in;
   logic signed [AW-1:0]               acc_ff, acc_in;
   logic [gcst_pkg::ELAP_W-1:0]        elap_ff, elap_in;

   // Pipeline registers
   logic signed [gcst_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [gcst_pkg::MS_W-1:0]          ms_ff, ms_in;
   logic signed [gcst_pkg::INC_W-1:0]  inc_ff, inc_in;
   logic [AW-1:0]                      absacc_ff, absacc_in;
   logic [gcst_pkg::REM_W-1:0]         tm1000_ff, tm1000_in;
   logic [gcst_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [gcst_pkg::SCALED_W-1:0]      scaled_ff, scaled_in;
   logic [gcst_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic                               drive_ff, drive_in;
   logic                               turn_ff, turn_in;
   logic                               tmo_ff, tmo_in;

   // Result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [gcst_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic [gcst_pkg::TGT_W-1:0]         tgt_mag;
   logic                               tgt_small;
   logic [gcst_pkg::MAG_W-1:0]         tgt_sat;
   logic signed [gcst_pkg::INC_W-1:0]  mul_prod;
   logic [gcst_pkg::ELAP_W:0]          elap_sum;
   logic signed [AW:0]                 acc_sum;
   logic                               beyond;
   logic [gcst_pkg::REM_W-1:0]         rem_diff;
   logic [gcst_pkg::REM_W-1:0]         tol1000;
   logic                               stop_tol;
   logic                               stop_tmo;
   logic [gcst_pkg::SCALE_W-1:0]       scale_prod;
   logic [gcst_pkg::RECIP_PW-1:0]      recip_prod;
   logic [gcst_pkg::SPD_MAG_W-1:0]     capped;
   logic [gcst_pkg::SPD_MAG_W-1:0]     floored;
   logic signed [gcst_pkg::SPD_W-1:0]  spd_pos;
   logic signed [gcst_pkg::SPD_W-1:0]  spd_neg;
   logic signed [gcst_pkg::SPD_W-1:0]  left_spd;
   logic signed [gcst_pkg::SPD_W-1:0]  right_spd;

   // Split the request payload
   assign req_target = req_tdata[gcst_pkg::TGT_W-1:0];
   assign req_rate   = req_tdata[gcst_pkg::TGT_W+gcst_pkg::RATE_W-1:gcst_pkg::TGT_W];
   assign req_ms     = req_tdata[gcst_pkg::REQ_DATA_W-1:gcst_pkg::TGT_W+gcst_pkg::RATE_W];

   // Target magnitude, small-target test and saturation of the most negative code
   assign tgt_mag   = req_target[gcst_pkg::TGT_W-1] ? (~req_target + 1'b1) : req_target;
   assign tgt_small = tgt_mag <= gcst_pkg::TGT_W'(1);
   assign tgt_sat   = (tgt_mag > gcst_pkg::TGT_W'(gcst_pkg::MAG_MAX)) ?
                      gcst_pkg::MAG_MAX : tgt_mag[gcst_pkg::MAG_W-1:0];

   // Angle increment: negated rate times milliseconds
   assign mul_prod = gcst_pkg::INC_W'(rate_ff) * gcst_pkg::INC_W'($signed({1'b0, ms_ff}));
   assign elap_sum = {1'b0, elap_ff} + (gcst_pkg::ELAP_W+1)'(ms_ff);

   // Saturating accumulate
   assign acc_sum = {acc_ff[AW-1], acc_ff}
                  + {{(AW+1-gcst_pkg::INC_W){inc_ff[gcst_pkg::INC_W-1]}}, inc_ff};

   // Remaining angle against tolerance and timeout
   assign beyond   = absacc_ff > AW'(tm1000_ff);
   assign rem_diff = tm1000_ff - absacc_ff[gcst_pkg::REM_W-1:0];
   assign tol1000  = gcst_pkg::REM_W'(cfg.tolerance) * gcst_pkg::REM_W'(gcst_pkg::MILLI);
   assign stop_tol = beyond || (rem_diff <= tol1000);
   assign stop_tmo = elap_ff > gcst_pkg::ELAP_W'(cfg.timeout_ms);

   // Speed = remaining * gain / 16000, as a shift by 7 then a reciprocal multiply for /125
   assign scale_prod = gcst_pkg::SCALE_W'(rem_ff) * gcst_pkg::SCALE_W'(cfg.slowdown_gain);
   assign recip_prod = gcst_pkg::RECIP_PW'(scaled_ff) * gcst_pkg::RECIP_PW'(gcst_pkg::RECIP_MUL);

   // Cap at the speed limit, floor at the minimum, then sign per wheel, or zero when not driving
   assign capped    = (quo_ff > gcst_pkg::QUO_W'(cfg.speed_limit)) ?
                      cfg.speed_limit : quo_ff[gcst_pkg::SPD_MAG_W-1:0];
   assign floored   = (capped < gcst_pkg::MIN_SPEED) ? gcst_pkg::MIN_SPEED : capped;
   assign spd_pos   = $signed({1'b0, floored});
   assign spd_neg   = -spd_pos;
   assign left_spd  = !drive_ff ? '0 : (cw_ff ? spd_pos : spd_neg);
   assign right_spd = !drive_ff ? '0 : (cw_ff ? spd_neg : spd_pos);

   // Next-state logic of all datapath registers
   always_comb begin
      active_in    = active_ff;
      cw_in        = cw_ff;
      target_in    = target_ff;
      acc_in       = acc_ff;
      elap_in      = elap_ff;
      rate_in      = rate_ff;
      ms_in        = ms_ff;
      inc_in       = inc_ff;
      absacc_in    = absacc_ff;
      tm1000_in    = tm1000_ff;
      rem_in       = rem_ff;
      scaled_in    = scaled_ff;
      quo_in       = quo_ff;
      drive_in     = drive_ff;
      turn_in      = turn_ff;
      tmo_in       = tmo_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // Take in a transaction; a start is settled right here
      if (cmd.capture) begin
         rate_in  = req_rate;
         ms_in    = (req_ms == '0) ? gcst_pkg::MS_W'(1) : req_ms;
         drive_in = 1'b0;
         tmo_in   = 1'b0;
         if (req_tuser == gcst_pkg::OP_START) begin
            if (tgt_small) begin
               active_in = 1'b0;
               turn_in   = 1'b0;
            end else begin
               active_in = 1'b1;
               cw_in     = !req_target[gcst_pkg::TGT_W-1];
               target_in = tgt_sat;
               acc_in    = '0;
               elap_in   = '0;
               turn_in   = 1'b1;
            end
         end else begin
            turn_in = 1'b0;
         end
      end

      // Form the increment and advance elapsed time
      if (cmd.do_mul) begin
         inc_in  = -mul_prod;
         elap_in = elap_sum[gcst_pkg::ELAP_W] ? gcst_pkg::ELAPSED_MAX :
                   elap_sum[gcst_pkg::ELAP_W-1:0];
      end

      // Integrate with saturation
      if (cmd.do_acc) begin
         if (acc_sum[AW] != acc_sum[AW-1]) begin
            acc_in = acc_sum[AW] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_in = acc_sum[AW-1:0];
         end
      end

      // Magnitude of the turned angle and the target in fine units
      if (cmd.do_abs) begin
         absacc_in = acc_ff[AW-1] ? (~acc_ff + 1'b1) : acc_ff;
         tm1000_in = gcst_pkg::REM_W'(target_ff) * gcst_pkg::REM_W'(gcst_pkg::MILLI);
      end

      // Decide stop; tolerance wins over timeout
      if (cmd.do_cmp) begin
         rem_in   = rem_diff;
         drive_in = !stop_tol && !stop_tmo;
         turn_in  = !stop_tol && !stop_tmo;
         tmo_in   = !stop_tol && stop_tmo;
         if (stop_tol || stop_tmo) begin
            active_in = 1'b0;
         end
      end

      if (cmd.do_scale) begin
         scaled_in = scale_prod[gcst_pkg::SCALE_W-1:gcst_pkg::PRE_SHIFT];
      end

      if (cmd.do_recip) begin
         quo_in = recip_prod[gcst_pkg::RECIP_SHIFT+gcst_pkg::QUO_W-1:gcst_pkg::RECIP_SHIFT];
      end

      // Load the result register
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {tmo_ff, turn_ff, right_spd, left_spd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cw_ff       <= cw_in;
      target_ff   <= target_in;
      acc_ff      <= acc_in;
      elap_ff     <= elap_in;
      rate_ff     <= rate_in;
      ms_ff       <= ms_in;
      inc_ff      <= inc_in;
      absacc_ff   <= absacc_in;
      tm1000_ff   <= tm1000_in;
      rem_ff      <= rem_in;
      scaled_ff   <= scaled_in;
      quo_ff      <= quo_in;
      drive_ff    <= drive_in;
      turn_ff     <= turn_in;
      tmo_ff      <= tmo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign sts.path_full = (req_tuser == gcst_pkg::OP_TICK) && active_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

FILE: src/gcst_ctrl.sv
// Controller of the spin turn unit: sequences the datapath steps of one transaction.
// Depends on gcst_pkg command and status types and on the assertion macro header.
`default_nettype none
`include "gyro_closed_loop_spin_turn_unit_macros.svh"

module gcst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  gcst_pkg::sts_type   sts,
   output gcst_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_ABS,
      ST_CMP,
      ST_SCALE,
      ST_RECIP,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   // Accept only between transactions
   assign req_tready = (state_ff == ST_IDLE);

   // Decode commands from the current step
   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.do_mul   = (state_ff == ST_MUL);
      cmd.do_acc   = (state_ff == ST_ACC);
      cmd.do_abs   = (state_ff == ST_ABS);
      cmd.do_cmp   = (state_ff == ST_CMP);
      cmd.do_scale = (state_ff == ST_SCALE);
      cmd.do_recip = (state_ff == ST_RECIP);
      cmd.load     = (state_ff == ST_OUT) && sts.out_free;
   end

   // Advance through the steps; start and idle ticks go straight to the result
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.path_full ? ST_MUL : ST_OUT;
            end
         end
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_ABS;
         ST_ABS:   state_in = ST_CMP;
         ST_CMP:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_RECIP;
         ST_RECIP: state_in = ST_OUT;
         ST_OUT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted transaction is always worked on
   `GCST_ASSERT_NEXT(a_capture_leaves_idle, cmd.capture, state_ff != ST_IDLE)
   // A loaded result frees the controller for the next transaction
   `GCST_ASSERT_NEXT(a_load_returns_idle, cmd.load, state_ff == ST_IDLE)
   // The increment is always integrated right after it is formed
   `GCST_ASSERT_NEXT(a_mul_then_acc, state_ff == ST_MUL, state_ff == ST_ACC)

endmodule

`default_nettype wire

FILE: src/gyro_closed_loop_spin_turn_unit.sv
// Top level of the gyro closed-loop spin turn unit.
// Instantiates gcst_csr, gcst_ctrl and gcst_dp; depends on gcst_pkg.
//
// Usage:
//   req channel: one transaction per command. req_tuser is the opcode (start or
//   tick); req_tdata carries target angle, gyro rate and elapsed milliseconds.
//   rsp channel: exactly one result per request, in order: left and right wheel
//   speeds plus turning and timed-out flags.
//   csr channel: register writes by index, always ready; write only while idle.
// Sequencing:
//   A start, or a tick while no turn is armed, goes from acceptance straight to the
//   output load step, which raises rsp_tvalid. A tick during a turn runs through the
//   steps multiply, accumulate, magnitude, compare, gain scale, reciprocal divide and
//   output load, in that order. One request is worked on at a time and the next is
//   taken the cycle after the load.
// Reset: the turn is disarmed, the result register is empty and the registers
//   return to speed limit 400, gain 15, tolerance 32 and timeout 5000 ms.
// Stall: a result waits in the output register while rsp_tready is low; the next
//   request is still accepted and its result held back until the register frees.
`default_nettype none

module gyro_closed_loop_spin_turn_unit (
   input  logic                                clock,
   input  logic                                reset,
   // target_angle[13:0], gyro_rate[29:14], elapsed_ms[39:30]
   input  logic [gcst_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode[0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // left_speed[10:0], right_speed[21:11], turning[22], timed_out[23]
   output logic [gcst_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gcst_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gcst_pkg::CSR_DATA_W-1:0]     csr_data
);

   gcst_pkg::cfg_type cfg;
   gcst_pkg::cmd_type cmd;
   gcst_pkg::sts_type sts;

   gcst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gcst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gcst_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .sts        (sts)
   );

endmodule

`default_nettype wire

FILE: bench/gcst_turn_monitor.sv
// Checker for the spin turn unit: watches the request, result and register channels.
// Predicts each wheel command from the accepted requests and compares it field by field.
// Depends on gcst_pkg for widths, opcodes, register indexes and reset values.
module gcst_turn_monitor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [gcst_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [gcst_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [gcst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gcst_pkg::CSR_DATA_W-1:0]    csr_data,
   output int unsigned                        outstanding,
   output int unsigned                        mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [gcst_pkg::SPD_W-1:0] left;
      logic signed [gcst_pkg::SPD_W-1:0] right;
      logic                              turning;
      logic                              timed_out;
   } wheel_cmd_type;

   // Shadow of the register file and of the turn state
   gcst_pkg::cfg_type settings;
   logic              armed;
   logic              clockwise;
   longint            target_mag;
   longint            heading_acc;
   longint            elapsed_sum;

   wheel_cmd_type     cmd_q[$];
   int unsigned       fault_count = 0;

   // Work out the wheel command that one request causes and advance the turn state
   function automatic wheel_cmd_type predict_command(logic op,
                                                     logic [gcst_pkg::TGT_W-1:0] tgt_bits,
                                                     logic [gcst_pkg::RATE_W-1:0] rate_bits,
                                                     logic [gcst_pkg::MS_W-1:0] ms_bits);
      wheel_cmd_type cmd;
      longint        target;
      longint        mag;
      longint        rate;
      longint        ms;
      longint        acc_hi;
      longint        acc_lo;
      longint        abs_acc;
      longint        remaining;
      longint        speed;
      cmd.left      = '0;
      cmd.right     = '0;
      cmd.turning   = 1'b0;
      cmd.timed_out = 1'b0;
      acc_hi = (longint'(1) <<< (gcst_pkg::ACCUM_WIDTH - 1)) - 1;
      acc_lo = -acc_hi - 1;
      if (op == gcst_pkg::OP_START) begin
         target = $signed(tgt_bits);
         mag = (target < 0) ? -target : target;
         // magnitude of 1 or below: cancel and stay idle
         if (mag <= 1) begin
            armed = 1'b0;
         end else begin
            if (mag > longint'(gcst_pkg::MAG_MAX)) mag = longint'(gcst_pkg::MAG_MAX);
            armed       = 1'b1;
            clockwise   = (target > 0);
            target_mag  = mag;
            heading_acc = 0;
            elapsed_sum = 0;
            cmd.turning = 1'b1;
         end
      end else if (armed) begin
         rate = $signed(rate_bits);
         ms   = (ms_bits == '0) ? 1 : longint'(ms_bits);
         // integrate the negated rate, saturating at the accumulator range
         heading_acc = heading_acc - rate * ms;
         if (heading_acc > acc_hi) heading_acc = acc_hi;
         if (heading_acc < acc_lo) heading_acc = acc_lo;
         elapsed_sum = elapsed_sum + ms;
         if (elapsed_sum > longint'(gcst_pkg::ELAPSED_MAX))
            elapsed_sum = longint'(gcst_pkg::ELAPSED_MAX);
         abs_acc = (heading_acc < 0) ? -heading_acc : heading_acc;
         // past the target counts as inside the tolerance
         remaining = (abs_acc > target_mag * 1000) ? -1 : target_mag * 1000 - abs_acc;
         if (remaining <= longint'(settings.tolerance) * 1000) begin
            armed = 1'b0;
         end else if (elapsed_sum > longint'(settings.timeout_ms)) begin
            armed         = 1'b0;
            cmd.timed_out = 1'b1;
         end else begin
            speed = remaining * longint'(settings.slowdown_gain) / 16000;
            if (speed > longint'(settings.speed_limit)) speed = longint'(settings.speed_limit);
            if (speed < longint'(gcst_pkg::MIN_SPEED)) speed = longint'(gcst_pkg::MIN_SPEED);
            cmd.turning = 1'b1;
            cmd.left    = gcst_pkg::SPD_W'(clockwise ? speed : -speed);
            cmd.right   = gcst_pkg::SPD_W'(clockwise ? -speed : speed);
         end
      end
      return cmd;
   endfunction

   function automatic void check_field(string what, longint want, longint got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      wheel_cmd_type want;
      if (reset) begin
         settings.speed_limit   = gcst_pkg::SPEED_LIMIT_RST;
         settings.slowdown_gain = gcst_pkg::SLOWDOWN_GAIN_RST;
         settings.tolerance     = gcst_pkg::TOLERANCE_RST;
         settings.timeout_ms    = gcst_pkg::TIMEOUT_MS_RST;
         armed       = 1'b0;
         clockwise   = 1'b0;
         target_mag  = 0;
         heading_acc = 0;
         elapsed_sum = 0;
         cmd_q.delete();
      end else begin
         // mirror register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gcst_pkg::REG_SPEED_LIMIT:   settings.speed_limit   = csr_data[9:0];
               gcst_pkg::REG_SLOWDOWN_GAIN: settings.slowdown_gain = csr_data[7:0];
               gcst_pkg::REG_TOLERANCE:     settings.tolerance     = csr_data[7:0];
               gcst_pkg::REG_TIMEOUT_MS:    settings.timeout_ms    = csr_data[15:0];
               default: ;
            endcase
         end
         // compare each result transaction with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_q.size() == 0) begin
               $display("%0t ns: result %h arrived with no prediction pending, expected none",
                        $time, rsp_tdata);
               fault_count++;
            end else begin
               want = cmd_q.pop_front();
               check_field("left_speed", want.left, $signed(rsp_tdata[10:0]));
               check_field("right_speed", want.right, $signed(rsp_tdata[21:11]));
               check_field("turning", want.turning, rsp_tdata[22]);
               check_field("timed_out", want.timed_out, rsp_tdata[23]);
            end
         end
         // predict from each request transaction
         if (req_tvalid && req_tready)
            cmd_q.push_back(predict_command(req_tuser, req_tdata[13:0], req_tdata[29:14],
                                            req_tdata[39:30]));
      end
      outstanding <= cmd_q.size();
      mismatches  <= fault_count;
   end

endmodule

FILE: bench/gyro_closed_loop_spin_turn_unit_test.sv
// Top of the spin turn unit testbench: clock, reset, stimulus, stalls and verdict.
// Instantiates gyro_closed_loop_spin_turn_unit and gcst_turn_monitor; uses gcst_pkg.
module gyro_closed_loop_spin_turn_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 250;
   localparam int QUIET_LIMIT = 2000;
   localparam int ITEM_GOAL   = 1300;

   logic                              clock;
   logic                              reset;
   logic [gcst_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic                              req_tuser;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [gcst_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [gcst_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [gcst_pkg::CSR_DATA_W-1:0]   csr_data;
   int unsigned                       outstanding;
   int unsigned                       mismatches;

   bit                                hold_rsp  = 1'b0;
   bit                                rsp_quick = 1'b0;
   int                                items_sent = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   gyro_closed_loop_spin_turn_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   gcst_turn_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // Offer one request transaction after a random gap, or none when quick, and hold it until accepted
   task automatic send_item(logic op, int tgt, int rate, int ms, bit quick);
      int gap;
      gap = quick ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {10'(ms), 16'(rate), 14'(tgt)};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Drop valid and wait until every predicted result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic put_reg(logic [gcst_pkg::CSR_IDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 16'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(int limit, int gain, int tol, int tmo);
      put_reg(gcst_pkg::REG_SPEED_LIMIT, limit);
      put_reg(gcst_pkg::REG_SLOWDOWN_GAIN, gain);
      put_reg(gcst_pkg::REG_TOLERANCE, tol);
      put_reg(gcst_pkg::REG_TIMEOUT_MS, tmo);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_target();
      logic [13:0] raw;
      int          target;
      raw = 14'($urandom);
      case ($urandom_range(0, 9))
         0:       target = int'($urandom_range(0, 2)) - 1;
         1:       target = $signed(raw);
         default: begin
            target = $urandom_range(32, 5760);
            if ($urandom_range(0, 1) == 1) target = -target;
         end
      endcase
      return target;
   endfunction

   // One start, then ticks whose rate roughly completes the turn in 3 to 20 samples
   task automatic run_turn(bit quick);
      logic [15:0] raw;
      int          target;
      int          mag;
      int          pace;
      int          ticks;
      int          ms;
      int          rate;
      target = pick_target();
      mag    = (target < 0) ? -target : target;
      pace   = $urandom_range(3, 20);
      ticks  = $urandom_range(1, pace + 4);
      send_item(gcst_pkg::OP_START, target, $urandom, $urandom, quick);
      for (int k = 0; k < ticks; k++) begin
         case ($urandom_range(0, 15))
            0:       ms = 0;
            1:       ms = $urandom_range(100, 1000);
            default: ms = $urandom_range(1, 25);
         endcase
         if ($urandom_range(0, 7) == 0) begin
            raw  = 16'($urandom);
            rate = $signed(raw);
         end else begin
            rate = (mag * 1000 / pace) / ((ms == 0) ? 1 : ms);
            rate = rate + rate * (int'($urandom_range(0, 60)) - 30) / 100;
            // gyro counts counterclockwise, so a clockwise turn sees negative rates
            if (target > 0) rate = -rate;
            if (rate > 32767) rate = 32767;
            if (rate < -32768) rate = -32768;
         end
         // occasionally restart in the middle of a turn
         if ($urandom_range(0, 29) == 0)
            send_item(gcst_pkg::OP_START, pick_target(), $urandom, $urandom, quick);
         send_item(gcst_pkg::OP_TICK, $urandom, rate, ms, quick);
      end
   endtask

   // Accept results after random stalls; hold off for a long stretch on request
   initial begin : receiver
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         stall = rsp_quick ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // End the run when no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      bit quick;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= gcst_pkg::OP_START;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= gcst_pkg::REG_SPEED_LIMIT;
      csr_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings
      send_item(gcst_pkg::OP_TICK, 0, 32767, 1000, 1'b0);     // idle tick, extremes
      send_item(gcst_pkg::OP_TICK, -1, -32768, 0, 1'b0);
      send_item(gcst_pkg::OP_START, 0, 0, 0, 1'b0);           // below threshold
      send_item(gcst_pkg::OP_START, 1, 0, 0, 1'b0);
      send_item(gcst_pkg::OP_START, -1, 0, 0, 1'b0);
      send_item(gcst_pkg::OP_START, 2, 0, 0, 1'b0);           // smallest armed turn
      send_item(gcst_pkg::OP_TICK, 0, 0, 0, 1'b0);            // zero ms, inside tolerance
      send_item(gcst_pkg::OP_START, 5760, 0, 0, 1'b0);
      send_item(gcst_pkg::OP_TICK, 0, -1600, 10, 1'b0);
      send_item(gcst_pkg::OP_TICK, 0, -32768, 100, 1'b0);     // speed capped
      send_item(gcst_pkg::OP_TICK, 0, 32767, 50, 1'b0);       // wrong way
      send_item(gcst_pkg::OP_START, -5760, 0, 0, 1'b0);       // restart while turning
      send_item(gcst_pkg::OP_TICK, 0, 32767, 1000, 1'b0);     // overshoot
      send_item(gcst_pkg::OP_START, -8192, 0, 0, 1'b0);       // most negative saturates
      repeat (6) send_item(gcst_pkg::OP_TICK, 0, 0, 1000, 1'b0); // runs into the timeout
      send_item(gcst_pkg::OP_START, 8191, 0, 0, 1'b0);
      send_item(gcst_pkg::OP_TICK, 0, -100, 3, 1'b0);
      send_item(gcst_pkg::OP_START, 0, 0, 0, 1'b0);           // cancel a running turn
      send_item(gcst_pkg::OP_TICK, 0, -5000, 7, 1'b0);
      drain();

      // High limit, full gain, zero tolerance and a long timeout
      load_settings(1000, 255, 0, 60000);
      while (items_sent < 250) run_turn($urandom_range(0, 4) == 0);
      drain();

      // Lower extremes: zero limit and gain, widest tolerance, immediate timeout
      load_settings(0, 0, 160, 0);
      while (items_sent < 400) run_turn($urandom_range(0, 4) == 0);
      drain();

      // Long result hold-off while requests keep coming
      load_settings(400, 15, 32, 60000);
      hold_rsp <= 1'b1;
      send_item(gcst_pkg::OP_START, 5000, 0, 0, 1'b1);
      repeat (40) send_item(gcst_pkg::OP_TICK, 0, -10, 1, 1'b1);
      drain();

      // Random settings, a phase each
      while (items_sent < ITEM_GOAL) begin
         load_settings($urandom_range(0, 1000), $urandom_range(0, 255), $urandom_range(0, 160),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60000)
                                                   : $urandom_range(20, 600));
         repeat (12) begin
            quick = ($urandom_range(0, 4) == 0);
            rsp_quick <= quick;
            run_turn(quick);
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: gyro_closed_loop_spin_turn_unit.f
+incdir+src
src/gcst_pkg.sv
src/gcst_csr.sv
src/gcst_dp.sv
src/gcst_ctrl.sv
src/gyro_closed_loop_spin_turn_unit.sv
bench/gcst_turn_monitor.sv
bench/gyro_closed_loop_spin_turn_unit_test.sv
